// ----- src/dpm_pkg.sv -----
// Shared constants, codes and types of the demand-paging memory unit.
`timescale 1ns / 1ps

package dpm_pkg;

  localparam int PAGE_SHIFT_DEF = 3;
  localparam int MEM_BYTES_DEF  = 64;

  localparam int ADDR_W    = 12;
  localparam int SEG_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_SEGS  = 4;
  localparam int CLOCK_W   = 32;
  localparam int SLOT_WORD = 8;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TEXT      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNALLOC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SWAP_FULL = 3'd4;

  localparam logic [SEG_W-1:0] SEG_TEXT = 2'd0;
  localparam logic [SEG_W-1:0] SEG_DATA = 2'd1;
  localparam logic [SEG_W-1:0] SEG_BSS  = 2'd2;
  localparam logic [SEG_W-1:0] SEG_HEAP = 2'd3;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOOK, S_SCAN, S_DEC, S_HIT_RD, S_VRD, S_VCHK,
    S_SRD, S_SCHK, S_OUT_RD, S_OUT_WR, S_SFR, S_SFW, S_FILL_RD,
    S_FILL_WR, S_DONE
  } dpm_state_t;

  typedef enum logic [1:0] {SRC_SWAP, SRC_IMAGE, SRC_ZERO} dpm_src_t;

endpackage

// ----- src/dpm_in_if.sv -----
// Request channel into the paging unit.
`timescale 1ns / 1ps

interface dpm_in_if;
  logic                        valid;
  logic                        ready;
  logic [dpm_pkg::KIND_W-1:0]  kind;
  logic [dpm_pkg::ADDR_W-1:0]  address;
  logic [dpm_pkg::BYTE_W-1:0]  write_data;

  modport source (output valid, output kind, output address, output write_data, input ready);
  modport sink   (input valid, input kind, input address, input write_data, output ready);
endinterface

// ----- src/dpm_out_if.sv -----
// Result channel out of the paging unit.
`timescale 1ns / 1ps

interface dpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpm_pkg::BYTE_W-1:0]    read_data;
  logic [dpm_pkg::STATUS_W-1:0]  status;
  logic                          page_fault;
  logic                          evicted;

  modport source (output valid, output read_data, output status, output page_fault,
                  output evicted, input ready);
  modport sink   (input valid, input read_data, input status, input page_fault,
                  input evicted, output ready);
endinterface

// ----- src/dpm_cfg_if.sv -----
// Register write channel of the paging unit.
`timescale 1ns / 1ps

interface dpm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dpm_pkg::CFG_IDX_W-1:0]  index;
  logic [dpm_pkg::BYTE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/dpm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- src/demand_paging_mmu_lru.sv -----
// Demand-paging memory unit with LRU replacement: top level and sequencer.
// Flow: a preload or error request goes straight to the result; a load or store looks up its
// entry and scans the NF frames, one per scan step. A fault fills the page byte by byte, frees
// its swap slot if it came from swap, and for a dirty victim first searches a free slot word by
// word and copies the victim page out. One request at a time; a single frame-table compare unit.
// Reset: synchronous, active low; a pass over all 4*2^(10-PAGE_SHIFT) entries (512 at default) clears
// the page-table and swap-slot RAMs, no requests taken meanwhile.
`timescale 1ns / 1ps

module demand_paging_mmu_lru #(
  parameter int PAGE_SHIFT = dpm_pkg::PAGE_SHIFT_DEF,
  parameter int MEM_BYTES  = dpm_pkg::MEM_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dpm_in_if.sink     in_if,
  dpm_out_if.source  out_if,
  dpm_cfg_if.sink    cfg_if
);
  import dpm_pkg::*;

  // geometry
  localparam int PB     = 1 << PAGE_SHIFT;
  localparam int PNW    = 10 - PAGE_SHIFT;
  localparam int PPS    = 1 << PNW;
  localparam int NF_RAW = MEM_BYTES >> PAGE_SHIFT;
  localparam int NF     = (NF_RAW > 0) ? NF_RAW : 1;
  localparam int FW     = (NF > 1) ? $clog2(NF) : 1;
  localparam int NENT   = 4 * PPS;
  localparam int EAW    = PNW + 2;
  localparam int SLOTS  = 3 * PPS;
  localparam int SLW    = $clog2(SLOTS);
  localparam int STB    = SLOTS * PB;
  localparam int SAW    = $clog2(STB);
  localparam int SWD    = (SLOTS + SLOT_WORD - 1) / SLOT_WORD;
  localparam int SWAW   = (SWD > 1) ? $clog2(SWD) : 1;
  localparam int FDEP   = NF * PB;
  localparam int FAW    = $clog2(FDEP);
  localparam int CW     = SLW + 4;
  localparam int PCW    = PNW + BYTE_W;

  function automatic logic [PNW:0] clamp_len(input logic [BYTE_W-1:0] n);
    if (PCW'(n) > PCW'(PPS)) begin
      return (PNW+1)'(PPS);
    end
    return (PNW+1)'(n);
  endfunction

  // segment length registers
  logic [BYTE_W-1:0] seg_len_r [NUM_SEGS];
  logic [PNW:0]      len0, len1, len2, len3;
  logic [PNW+2:0]    lim_slots;

  // sequencer state
  dpm_state_t state_r, state_nxt;
  logic [EAW-1:0]     clr_r;
  logic [CLOCK_W-1:0] clock_r;

  // current request
  logic                is_store_r;
  logic [SEG_W-1:0]    seg_q_r;
  logic [PNW-1:0]      page_q_r;
  logic [PAGE_SHIFT-1:0] off_q_r;
  logic [BYTE_W-1:0]   wd_r;
  logic [EAW-1:0]      e_q;
  logic                e_dirty_r;
  logic [SLW-1:0]      e_slot_r;

  // frame table: owner entry and last use of each frame
  logic [NF-1:0]       fr_used_r;
  logic [EAW-1:0]      fr_owner_r [NF];
  logic [CLOCK_W-1:0]  fr_lu_r [NF];

  // frame scan
  logic [FW-1:0]       scan_r;
  logic                hit_r, free_found_r, vic_found_r;
  logic [FW-1:0]       hit_f_r, free_f_r, vic_f_r, tgt_f_r;
  logic [CLOCK_W-1:0]  vic_lu_r;
  logic [EAW-1:0]      vic_owner_r;
  logic                vic_lt;

  // swap slot search and page copy
  logic [SWAW:0]       sw_r;
  logic [SLW-1:0]      slot_r;
  logic [PAGE_SHIFT-1:0] cnt_r;
  logic                cnt_last;
  dpm_src_t            src_r, dec_src;
  logic                err3;
  logic                slot_found;
  logic [2:0]          slot_bit;
  logic [SLW-1:0]      found_slot;
  logic                slot_fail;
  logic [CW-1:0]       sw_base;
  logic [PNW+1:0]      img_base, img_pg;
  logic [BYTE_W-1:0]   fill_byte;

  // results
  logic [BYTE_W-1:0]   res_rd_r;
  logic [STATUS_W-1:0] res_st_r;
  logic                res_pf_r, res_ev_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_rd_r;
  logic [STATUS_W-1:0] out_st_r;
  logic                out_pf_r, out_ev_r;

  // input decode
  logic                in_fire, in_access;
  logic [SEG_W-1:0]    in_seg;
  logic [PNW-1:0]      in_page;
  logic [STATUS_W-1:0] in_status;

  // RAM ports
  logic                ent_we;
  logic [EAW-1:0]      ent_waddr, ent_raddr;
  logic [SLW:0]        ent_wdata, ent_q;
  logic                slt_we;
  logic [SWAW-1:0]     slt_waddr, slt_raddr;
  logic [SLOT_WORD-1:0] slt_wdata, slt_q;
  logic                frm_we;
  logic [FAW-1:0]      frm_waddr, frm_raddr;
  logic [BYTE_W-1:0]   frm_wdata, frm_q;
  logic                swp_we;
  logic [SAW-1:0]      swp_waddr, swp_raddr;
  logic [BYTE_W-1:0]   swp_wdata, swp_q;
  logic                img_we;
  logic [SAW-1:0]      img_waddr, img_raddr;
  logic [BYTE_W-1:0]   img_q;

  // ---------------------------------------------------------------------------------------
  // Configuration: always ready, indexes past the list are dropped
  // ---------------------------------------------------------------------------------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEGS; i++) begin
        seg_len_r[i] <= '0;
      end
    end else if (cfg_if.valid && (cfg_if.index < CFG_IDX_W'(NUM_SEGS))) begin
      seg_len_r[cfg_if.index[SEG_W-1:0]] <= cfg_if.data;
    end
  end

  assign len0 = clamp_len(seg_len_r[0]);
  assign len1 = clamp_len(seg_len_r[1]);
  assign len2 = clamp_len(seg_len_r[2]);
  assign len3 = clamp_len(seg_len_r[3]);
  // swap holds pages of data, bss and heap/stack only
  assign lim_slots = (PNW+3)'(len1) + (PNW+3)'(len2) + (PNW+3)'(len3);

  // ---------------------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------------------
  assign in_fire   = in_if.valid && in_if.ready;
  assign in_access = (in_if.kind == KIND_LOAD) || (in_if.kind == KIND_STORE);
  assign in_seg    = in_if.address[ADDR_W-1 -: SEG_W];
  assign in_page   = in_if.address[ADDR_W-SEG_W-1:PAGE_SHIFT];

  always_comb begin
    in_status = ST_OK;
    if (in_access) begin
      if (PCW'(in_page) >= PCW'(seg_len_r[in_seg])) begin
        in_status = ST_BEYOND;
      end else if ((in_if.kind == KIND_STORE) && (in_seg == SEG_TEXT)) begin
        in_status = ST_TEXT;
      end
    end
  end

  assign e_q = {seg_q_r, page_q_r};

  // Miss handling: where the missing page comes from
  assign err3 = !is_store_r && (seg_q_r == SEG_HEAP) && !e_dirty_r;
  always_comb begin
    if (e_dirty_r && (seg_q_r != SEG_TEXT)) begin
      dec_src = SRC_SWAP;
    end else if (!is_store_r || (seg_q_r == SEG_DATA)) begin
      dec_src = SRC_IMAGE;
    end else begin
      dec_src = SRC_ZERO;
    end
  end

  // image layout: text, then data, then bss
  always_comb begin
    case (seg_q_r)
      SEG_DATA: img_base = (PNW+2)'(len0);
      SEG_BSS:  img_base = (PNW+2)'(len0) + (PNW+2)'(len1);
      default:  img_base = '0;
    endcase
  end
  assign img_pg = img_base + (PNW+2)'(page_q_r);

  // LRU order: older use first, lower entry breaks a tie
  assign vic_lt = (fr_lu_r[scan_r] < vic_lu_r) ||
                  ((fr_lu_r[scan_r] == vic_lu_r) && (fr_owner_r[scan_r] < vic_owner_r));

  assign cnt_last = (cnt_r == PAGE_SHIFT'(PB - 1));

  // First free slot in the fetched word, below the swap size
  assign sw_base   = CW'({sw_r, 3'b000});
  assign slot_fail = (sw_base >= CW'(lim_slots));
  always_comb begin
    slot_found = 1'b0;
    slot_bit   = '0;
    for (int b = 0; b < SLOT_WORD; b++) begin
      if (!slot_found && !slt_q[b] && ((sw_base + CW'(b)) < CW'(lim_slots))) begin
        slot_found = 1'b1;
        slot_bit   = 3'(b);
      end
    end
  end
  assign found_slot = SLW'({sw_r, slot_bit});

  always_comb begin
    case (src_r)
      SRC_SWAP:  fill_byte = swp_q;
      SRC_IMAGE: fill_byte = img_q;
      default:   fill_byte = BYTE_ZERO;
    endcase
    if (is_store_r && (cnt_r == off_q_r)) begin
      fill_byte = wd_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == EAW'(NENT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_access && (in_status == ST_OK)) ? S_LOOK : S_DONE;
        end
      end
      S_LOOK: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_r == FW'(NF - 1)) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (hit_r) begin
          state_nxt = is_store_r ? S_DONE : S_HIT_RD;
        end else if (err3) begin
          state_nxt = S_DONE;
        end else if (free_found_r) begin
          state_nxt = (dec_src == SRC_SWAP) ? S_SFR : S_FILL_RD;
        end else begin
          state_nxt = S_VRD;
        end
      end
      S_HIT_RD: state_nxt = S_DONE;
      S_VRD:    state_nxt = S_VCHK;
      S_VCHK: begin
        if (ent_q[SLW]) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = (src_r == SRC_SWAP) ? S_SFR : S_FILL_RD;
        end
      end
      S_SRD:  state_nxt = slot_fail ? S_DONE : S_SCHK;
      S_SCHK: state_nxt = slot_found ? S_OUT_RD : S_SRD;
      S_OUT_RD: state_nxt = S_OUT_WR;
      S_OUT_WR: begin
        if (cnt_last) begin
          state_nxt = (src_r == SRC_SWAP) ? S_SFR : S_FILL_RD;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_SFR:     state_nxt = S_SFW;
      S_SFW:     state_nxt = S_FILL_RD;
      S_FILL_RD: state_nxt = S_FILL_WR;
      S_FILL_WR: state_nxt = cnt_last ? S_DONE : S_FILL_RD;
      S_DONE: begin
        if (!out_valid_r || out_if.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // RAM control
  // ---------------------------------------------------------------------------------------
  assign ent_raddr = (state_r == S_IDLE) ? in_if.address[ADDR_W-1:PAGE_SHIFT] : vic_owner_r;
  assign slt_raddr = (state_r == S_SRD) ? sw_r[SWAW-1:0] : SWAW'(e_slot_r >> 3);
  assign frm_raddr = (state_r == S_DEC) ? FAW'({hit_f_r, off_q_r}) : FAW'({vic_f_r, cnt_r});
  assign swp_raddr = SAW'({e_slot_r, cnt_r});
  assign img_raddr = SAW'({img_pg, cnt_r});
  assign img_waddr = SAW'(in_if.address);

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = e_q;
    ent_wdata = {1'b1, e_slot_r};
    slt_we    = 1'b0;
    slt_waddr = slt_raddr;
    slt_wdata = slt_q;
    frm_we    = 1'b0;
    frm_waddr = FAW'({tgt_f_r, cnt_r});
    frm_wdata = fill_byte;
    swp_we    = 1'b0;
    swp_waddr = SAW'({slot_r, cnt_r});
    swp_wdata = frm_q;
    img_we    = 1'b0;
    case (state_r)
      S_CLR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        ent_wdata = '0;
        if ({1'b0, clr_r} < (EAW+1)'(SWD)) begin
          slt_we    = 1'b1;
          slt_waddr = SWAW'(clr_r);
          slt_wdata = '0;
        end
      end
      S_IDLE: begin
        img_we = in_fire && (in_if.kind == KIND_PRELOAD) &&
                 ((ADDR_W+1)'(in_if.address) < (ADDR_W+1)'(STB));
      end
      S_DEC: begin
        if (hit_r && is_store_r) begin
          frm_we    = 1'b1;
          frm_waddr = FAW'({hit_f_r, off_q_r});
          frm_wdata = wd_r;
          ent_we    = 1'b1;
        end
      end
      S_SCHK: begin
        if (slot_found) begin
          slt_we    = 1'b1;
          slt_waddr = sw_r[SWAW-1:0];
          slt_wdata = slt_q | (SLOT_WORD'(1) << slot_bit);
        end
      end
      S_OUT_WR: begin
        swp_we = 1'b1;
        if (cnt_last) begin
          ent_we    = 1'b1;
          ent_waddr = vic_owner_r;
          ent_wdata = {1'b1, slot_r};
        end
      end
      S_SFW: begin
        slt_we    = 1'b1;
        slt_wdata = slt_q & ~(SLOT_WORD'(1) << e_slot_r[2:0]);
      end
      S_FILL_WR: begin
        frm_we = 1'b1;
        ent_we = cnt_last && is_store_r;
      end
      default: ;
    endcase
  end

  dpm_ram #(.WIDTH(SLW + 1), .DEPTH(NENT)) u_entry_ram (
    .clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
    .rd_addr(ent_raddr), .rd_data(ent_q)
  );

  dpm_ram #(.WIDTH(SLOT_WORD), .DEPTH(SWD)) u_slot_ram (
    .clk(clk), .wr_en(slt_we), .wr_addr(slt_waddr), .wr_data(slt_wdata),
    .rd_addr(slt_raddr), .rd_data(slt_q)
  );

  dpm_ram #(.WIDTH(BYTE_W), .DEPTH(FDEP)) u_frame_ram (
    .clk(clk), .wr_en(frm_we), .wr_addr(frm_waddr), .wr_data(frm_wdata),
    .rd_addr(frm_raddr), .rd_data(frm_q)
  );

  dpm_ram #(.WIDTH(BYTE_W), .DEPTH(STB)) u_swap_ram (
    .clk(clk), .wr_en(swp_we), .wr_addr(swp_waddr), .wr_data(swp_wdata),
    .rd_addr(swp_raddr), .rd_data(swp_q)
  );

  dpm_ram #(.WIDTH(BYTE_W), .DEPTH(STB)) u_image_ram (
    .clk(clk), .wr_en(img_we), .wr_addr(img_waddr), .wr_data(in_if.write_data),
    .rd_addr(img_raddr), .rd_data(img_q)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clock_r     <= '0;
      fr_used_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: clr_r <= clr_r + EAW'(1);
        S_IDLE: begin
          if (in_fire) begin
            is_store_r <= (in_if.kind == KIND_STORE);
            seg_q_r    <= in_seg;
            page_q_r   <= in_page;
            off_q_r    <= in_if.address[PAGE_SHIFT-1:0];
            wd_r       <= in_if.write_data;
            res_rd_r   <= '0;
            res_st_r   <= in_status;
            res_pf_r   <= 1'b0;
            res_ev_r   <= 1'b0;
            if (in_access) clock_r <= clock_r + CLOCK_W'(1);
          end
        end
        S_LOOK: begin
          e_dirty_r    <= ent_q[SLW];
          e_slot_r     <= ent_q[SLW-1:0];
          scan_r       <= '0;
          hit_r        <= 1'b0;
          free_found_r <= 1'b0;
          vic_found_r  <= 1'b0;
        end
        S_SCAN: begin
          if (fr_used_r[scan_r]) begin
            if (fr_owner_r[scan_r] == e_q) begin
              hit_r   <= 1'b1;
              hit_f_r <= scan_r;
            end
            if (!vic_found_r || vic_lt) begin
              vic_found_r <= 1'b1;
              vic_f_r     <= scan_r;
              vic_lu_r    <= fr_lu_r[scan_r];
              vic_owner_r <= fr_owner_r[scan_r];
            end
          end else if (!free_found_r) begin
            free_found_r <= 1'b1;
            free_f_r     <= scan_r;
          end
          scan_r <= scan_r + FW'(1);
        end
        S_DEC: begin
          src_r   <= dec_src;
          tgt_f_r <= free_f_r;
          cnt_r   <= '0;
          if (hit_r) begin
            fr_lu_r[hit_f_r] <= clock_r;
          end else if (err3) begin
            res_st_r <= ST_UNALLOC;
          end
        end
        S_HIT_RD: res_rd_r <= frm_q;
        S_VCHK: begin
          sw_r  <= '0;
          cnt_r <= '0;
          if (!ent_q[SLW]) begin
            tgt_f_r  <= vic_f_r;
            res_ev_r <= 1'b1;
          end
        end
        S_SRD: begin
          if (slot_fail) res_st_r <= ST_SWAP_FULL;
        end
        S_SCHK: begin
          if (slot_found) begin
            slot_r <= found_slot;
            cnt_r  <= '0;
          end else begin
            sw_r <= sw_r + (SWAW+1)'(1);
          end
        end
        S_OUT_WR: begin
          cnt_r <= cnt_r + PAGE_SHIFT'(1);
          if (cnt_last) begin
            tgt_f_r  <= vic_f_r;
            res_ev_r <= 1'b1;
          end
        end
        S_SFW: cnt_r <= '0;
        S_FILL_WR: begin
          cnt_r <= cnt_r + PAGE_SHIFT'(1);
          if (!is_store_r && (cnt_r == off_q_r)) res_rd_r <= fill_byte;
          if (cnt_last) begin
            fr_used_r[tgt_f_r]  <= 1'b1;
            fr_owner_r[tgt_f_r] <= e_q;
            fr_lu_r[tgt_f_r]    <= clock_r;
            res_pf_r            <= 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= res_rd_r;
            out_st_r    <= res_st_r;
            out_pf_r    <= res_pf_r;
            out_ev_r    <= res_ev_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.read_data  = out_rd_r;
  assign out_if.status     = out_st_r;
  assign out_if.page_fault = out_pf_r;
  assign out_if.evicted    = out_ev_r;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_access) |=> (clock_r == $past(clock_r) + CLOCK_W'(1)))
    else $error("access clock did not advance on a load or store");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_OK)) |-> (!out_pf_r && !out_ev_r && (out_rd_r == '0)))
    else $error("failed request reports data or a fault");

  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r) |-> out_pf_r)
    else $error("eviction reported without a page fault");

endmodule
